// ----- hw/rtl/sensor_registry_table_defines.svh -----
// ----------------------------------------------------------------------------
// sensor registry table assertion macros
// Concurrent check macros clocked on clk_i and disabled by rst_ni.
// ----------------------------------------------------------------------------
`ifndef SENSOR_REGISTRY_TABLE_DEFINES_SVH
`define SENSOR_REGISTRY_TABLE_DEFINES_SVH

// check a property on every rising clock edge outside reset
`define SRT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("sensor registry check failed");

// same, with a caller message
`define SRT_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

`endif

// ----- hw/rtl/srt_pkg.sv -----
// ----------------------------------------------------------------------------
// srt_pkg
// Shared types and constants of the sensor registry table.
// ----------------------------------------------------------------------------
package srt_pkg;

  localparam int unsigned SLOTS = 16;
  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned SEL_W = (IDX_W > 4) ? IDX_W : 4;
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);

  localparam logic [31:0] MS_PER_S  = 32'd1000;
  localparam logic [31:0] LIMIT_RST = 32'd300000;

  // item function codes
  localparam logic [1:0] FUNC_FRAME = 2'd0;
  localparam logic [1:0] FUNC_TICK  = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  // result status codes
  localparam logic [2:0] STAT_UPDATED = 3'd0;
  localparam logic [2:0] STAT_NEW     = 3'd1;
  localparam logic [2:0] STAT_FULL    = 3'd2;
  localparam logic [2:0] STAT_TICK    = 3'd3;
  localparam logic [2:0] STAT_READ    = 3'd4;

  typedef struct packed {
    logic [1:0]         func;
    logic [31:0]        node_id;
    logic [7:0]         node_kind;
    logic [7:0]         oper_mode;
    logic [7:0]         location;
    logic signed [15:0] temperature;
    logic signed [15:0] humidity;
    logic [15:0]        battery_mv;
    logic [15:0]        wakeup_s;
    logic [31:0]        runtime_s;
    logic [7:0]         batt_status;
    logic [3:0]         read_slot;
  } in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [3:0]         slot;
    logic               entry_valid;
    logic               lost_flag;
    logic [31:0]        entry_id;
    logic [31:0]        descriptor;
    logic signed [15:0] entry_temperature;
    logic signed [15:0] entry_humidity;
    logic [15:0]        entry_battery_mv;
    logic [15:0]        entry_wakeup_s;
    logic [31:0]        entry_runtime_s;
    logic [31:0]        entry_frames;
  } out_t;

  // contents of one slot as seen from outside the cell
  typedef struct packed {
    logic        valid;
    logic        lost;
    logic [31:0] id;
    logic [31:0] descriptor;
    logic [15:0] temperature;
    logic [15:0] humidity;
    logic [15:0] battery;
    logic [15:0] wakeup;
    logic [31:0] runtime;
    logic [31:0] frames;
  } entry_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic             free;
    logic [IDX_W-1:0] free_idx;
  } scan_t;

  // broadcast control from the sequencer to all cells
  typedef struct packed {
    logic             wr;
    logic [IDX_W-1:0] wr_idx;
    logic             flag;
    logic [31:0]      now;
    logic [31:0]      limit;
  } cell_ctl_t;

endpackage

// ----- hw/rtl/srt_cell.sv -----
// ----------------------------------------------------------------------------
// srt_cell
// One table slot: holds the entry, updates it, flags timeouts and passes the
// id and free-slot search token on to the next cell.
// ----------------------------------------------------------------------------
module srt_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [srt_pkg::IDX_W-1:0] slot_idx_i,
  input  srt_pkg::in_t              item_i,
  input  srt_pkg::cell_ctl_t        ctl_i,
  input  srt_pkg::scan_t            scan_i,
  output srt_pkg::scan_t            scan_o,
  output srt_pkg::entry_t           entry_o
);
  import srt_pkg::*;

  logic        valid_q, valid_d;
  logic        lost_q, lost_d;
  logic [31:0] frames_q, frames_d;
  logic [31:0] id_q, desc_q, run_q, last_rx_q;
  logic [15:0] temp_q, hum_q, batt_q, wake_q;
  logic        sel_wr;
  logic        timed_out;
  scan_t       scan_q, scan_d;

  assign sel_wr    = ctl_i.wr && (ctl_i.wr_idx == slot_idx_i);
  assign timed_out = valid_q && ((ctl_i.now - last_rx_q) >= ctl_i.limit);

  // search token update
  always_comb begin
    scan_d = scan_i;
    if (valid_q && (id_q == item_i.node_id) && !scan_i.hit) begin
      scan_d.hit     = 1'b1;
      scan_d.hit_idx = slot_idx_i;
    end
    if (!valid_q && !scan_i.free) begin
      scan_d.free     = 1'b1;
      scan_d.free_idx = slot_idx_i;
    end
  end

  // flag and counter next values
  always_comb begin
    valid_d  = valid_q;
    lost_d   = lost_q;
    frames_d = frames_q;
    if (sel_wr) begin
      valid_d  = 1'b1;
      lost_d   = 1'b0;
      frames_d = frames_q + 32'd1;
    end else if (ctl_i.flag && timed_out) begin
      lost_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      lost_q   <= 1'b0;
      frames_q <= '0;
      scan_q   <= '0;
    end else begin
      valid_q  <= valid_d;
      lost_q   <= lost_d;
      frames_q <= frames_d;
      scan_q   <= scan_d;
    end
  end

  // payload store
  always_ff @(posedge clk_i) begin
    if (sel_wr) begin
      id_q      <= item_i.node_id;
      desc_q    <= {item_i.node_kind, item_i.oper_mode, item_i.location,
                    item_i.batt_status};
      temp_q    <= item_i.temperature;
      hum_q     <= item_i.humidity;
      batt_q    <= item_i.battery_mv;
      wake_q    <= item_i.wakeup_s;
      run_q     <= item_i.runtime_s;
      last_rx_q <= ctl_i.now;
    end
  end

  assign scan_o              = scan_q;
  assign entry_o.valid       = valid_q;
  assign entry_o.lost        = lost_q;
  assign entry_o.id          = id_q;
  assign entry_o.descriptor  = desc_q;
  assign entry_o.temperature = temp_q;
  assign entry_o.humidity    = hum_q;
  assign entry_o.battery     = batt_q;
  assign entry_o.wakeup      = wake_q;
  assign entry_o.runtime     = run_q;
  assign entry_o.frames      = frames_q;

endmodule

// ----- hw/rtl/sensor_registry_table.sv -----
// ----------------------------------------------------------------------------
// sensor_registry_table
// Table of wireless sensors keyed by 32-bit id, with frame update, millisecond
// tick timeout flagging and slot read.
// ----------------------------------------------------------------------------
// Items are handled one at a time. A frame item passes through the scan, write
// and emit states from transfer to result: the id search token walks the row
// of slot cells one cell per cycle, then the write state writes the chosen slot
// and the emit state loads the output register. A tick passes through the tick
// (count), flag and emit (output) states, and a read goes straight to the emit
// state. An item with function code 3 is taken and dropped without a result.
// The next item is taken once the current one has its result in the output
// register; that register holds it until transferred, and a result still waiting there delays the load of the next one.
`include "sensor_registry_table_defines.svh"

module sensor_registry_table (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [15:0]    cfg_wdata_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  srt_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output srt_pkg::out_t  out_data_o
);
  import srt_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_WRITE = 3'd2;
  localparam logic [2:0] ST_TICK  = 3'd3;
  localparam logic [2:0] ST_FLAG  = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [31:0]      now_q, limit_q;
  logic [2:0]       status_q, status_d;
  logic [SEL_W-1:0] sel_q, sel_d;
  in_t              item_q;
  out_t             out_q, out_d;
  logic             out_valid_q, out_valid_d;
  logic             in_xfer, out_free, sel_in_range;
  logic             wr_hit, hit_id_ok;
  cell_ctl_t        ctl;
  scan_t            scan_chain [SLOTS+1];
  entry_t           entries [SLOTS];
  entry_t           rd;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign sel_in_range = ((SEL_W+1)'(sel_q) < (SEL_W+1)'(SLOTS));
  assign rd = entries[sel_q[IDX_W-1:0]];

  // row of slot cells
  assign scan_chain[0] = '0;
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    srt_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .slot_idx_i (IDX_W'(g)),
      .item_i     (item_q),
      .ctl_i      (ctl),
      .scan_i     (scan_chain[g]),
      .scan_o     (scan_chain[g+1]),
      .entry_o    (entries[g])
    );
  end

  // broadcast control
  always_comb begin
    ctl        = '0;
    ctl.now    = now_q;
    ctl.limit  = limit_q;
    ctl.flag   = (state_q == ST_FLAG);
    if (state_q == ST_WRITE) begin
      ctl.wr     = scan_chain[SLOTS].hit || scan_chain[SLOTS].free;
      ctl.wr_idx = scan_chain[SLOTS].hit ? scan_chain[SLOTS].hit_idx
                                         : scan_chain[SLOTS].free_idx;
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    status_d    = status_q;
    sel_d       = sel_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          cnt_d = '0;
          unique case (in_data_i.func)
            FUNC_FRAME: state_d = ST_SCAN;
            FUNC_TICK:  state_d = ST_TICK;
            FUNC_READ: begin
              status_d = STAT_READ;
              sel_d    = SEL_W'(in_data_i.read_slot);
              state_d  = ST_EMIT;
            end
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(SLOTS - 1)) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        sel_d = SEL_W'(ctl.wr_idx);
        if (scan_chain[SLOTS].hit) begin
          status_d = STAT_UPDATED;
        end else if (scan_chain[SLOTS].free) begin
          status_d = STAT_NEW;
        end else begin
          status_d = STAT_FULL;
        end
        state_d = ST_EMIT;
      end
      ST_TICK:  state_d = ST_FLAG;
      ST_FLAG: begin
        status_d = STAT_TICK;
        state_d  = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_d        = '0;
          out_d.status = status_q;
          if (status_q != STAT_FULL && status_q != STAT_TICK) begin
            out_d.slot = sel_q[3:0];
            if (sel_in_range && rd.valid) begin
              out_d.entry_valid       = 1'b1;
              out_d.lost_flag         = rd.lost;
              out_d.entry_id          = rd.id;
              out_d.descriptor        = rd.descriptor;
              out_d.entry_temperature = rd.temperature;
              out_d.entry_humidity    = rd.humidity;
              out_d.entry_battery_mv  = rd.battery;
              out_d.entry_wakeup_s    = rd.wakeup;
              out_d.entry_runtime_s   = rd.runtime;
              out_d.entry_frames      = rd.frames;
            end
          end
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      now_q       <= '0;
      limit_q     <= LIMIT_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (state_q == ST_TICK) begin
        now_q <= now_q + 32'd1;
      end
      if (cfg_we_i) begin
        limit_q <= 32'(cfg_wdata_i) * MS_PER_S;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    sel_q    <= sel_d;
    out_q    <= out_d;
    if (in_xfer) begin
      item_q <= in_data_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // search outcome seen by the checks
  assign wr_hit    = (state_q == ST_WRITE) && scan_chain[SLOTS].hit;
  assign hit_id_ok = (entries[scan_chain[SLOTS].hit_idx].id == item_q.node_id);

  // checks
  `SRT_ASSERT(a_tick_adds_one, (state_q == ST_TICK) |=> (now_q == $past(now_q) + 32'd1))
  `SRT_ASSERT(a_write_sets_valid, (state_q == ST_WRITE && ctl.wr) |=> rd.valid)
  `SRT_ASSERT_MSG(a_hit_matches, wr_hit |-> hit_id_ok, "search hit on wrong id")
  `SRT_ASSERT(a_result_from_emit, $rose(out_valid_q) |-> ($past(state_q) == ST_EMIT))

endmodule

// ----- test/sensor_registry_table_tb.sv -----
// ----------------------------------------------------------------------------
// sensor_registry_table_tb
// Self-checking bench for the sensor registry table. A behavioral copy of the
// table predicts every result of frame, tick and read items. Results are
// compared field by field in arrival order while both channels idle at random.
// ----------------------------------------------------------------------------
module sensor_registry_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srt_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int unsigned RUN_LIMIT = 1000000;
  localparam int unsigned SETTLE = 30;
  localparam int unsigned POOL = 20;

  logic  clk_i;
  logic  rst_ni;
  logic  cfg_we_i;
  logic  [15:0] cfg_wdata_i;
  logic  in_valid_i;
  logic  in_stall_o;
  in_t   in_data_i;
  logic  out_valid_o;
  logic  out_stall_i = 1'b0;
  out_t  out_data_o;

  sensor_registry_table DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // predicted table contents
  logic [15:0] timeout_s;
  logic [31:0] clock_ms;
  logic        tbl_valid [SLOTS];
  logic        tbl_lost  [SLOTS];
  logic [31:0] tbl_id    [SLOTS];
  logic [31:0] tbl_desc  [SLOTS];
  logic [15:0] tbl_temp  [SLOTS];
  logic [15:0] tbl_hum   [SLOTS];
  logic [15:0] tbl_batt  [SLOTS];
  logic [15:0] tbl_wake  [SLOTS];
  logic [31:0] tbl_run   [SLOTS];
  logic [31:0] tbl_rx_ms [SLOTS];
  logic [31:0] tbl_frames[SLOTS];

  out_t        pending_results[$];
  int          errors = 0;
  int          cycles = 0;
  bit          tx_idle_on;
  bit          rx_idle_on = 1'b1;
  bit          valid_high;
  int          rx_wait = 0;
  logic [31:0] id_pool[POOL];

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // fill the result fields from one slot
  function automatic out_t slot_view(input int s, input logic [2:0] st);
    out_t r;
    r = '0;
    r.status            = st;
    r.slot              = s[3:0];
    r.entry_valid       = tbl_valid[s];
    r.lost_flag         = tbl_lost[s];
    r.entry_id          = tbl_id[s];
    r.descriptor        = tbl_desc[s];
    r.entry_temperature = tbl_temp[s];
    r.entry_humidity    = tbl_hum[s];
    r.entry_battery_mv  = tbl_batt[s];
    r.entry_wakeup_s    = tbl_wake[s];
    r.entry_runtime_s   = tbl_run[s];
    r.entry_frames      = tbl_frames[s];
    return r;
  endfunction

  // apply one accepted item to the predicted table and queue its result
  task automatic registry_apply(input in_t it);
    out_t        r;
    int          hit;
    int          free_s;
    int          s;
    logic [31:0] limit_ms;
    r = '0;
    hit = -1;
    free_s = -1;
    case (it.func)
      FUNC_FRAME: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (tbl_valid[i] && tbl_id[i] == it.node_id && hit < 0) hit = i;
          if (!tbl_valid[i] && free_s < 0) free_s = i;
        end
        if (hit < 0 && free_s < 0) begin
          r.status = STAT_FULL;
        end else begin
          s = (hit >= 0) ? hit : free_s;
          tbl_id[s]     = it.node_id;
          tbl_desc[s]   = {it.node_kind, it.oper_mode, it.location, it.batt_status};
          tbl_temp[s]   = it.temperature;
          tbl_hum[s]    = it.humidity;
          tbl_batt[s]   = it.battery_mv;
          tbl_wake[s]   = it.wakeup_s;
          tbl_run[s]    = it.runtime_s;
          tbl_rx_ms[s]  = clock_ms;
          tbl_frames[s] = tbl_frames[s] + 32'd1;
          tbl_lost[s]   = 1'b0;
          tbl_valid[s]  = 1'b1;
          r = slot_view(s, (hit >= 0) ? STAT_UPDATED : STAT_NEW);
        end
      end
      FUNC_TICK: begin
        limit_ms = 32'(timeout_s) * MS_PER_S;
        clock_ms = clock_ms + 32'd1;
        for (int i = 0; i < SLOTS; i++)
          if (tbl_valid[i] && (clock_ms - tbl_rx_ms[i]) >= limit_ms) tbl_lost[i] = 1'b1;
        r.status = STAT_TICK;
      end
      FUNC_READ: begin
        if (tbl_valid[it.read_slot]) begin
          r = slot_view(int'(it.read_slot), STAT_READ);
        end else begin
          r.status = STAT_READ;
          r.slot   = it.read_slot;
        end
      end
      default: return;
    endcase
    pending_results.push_back(r);
  endtask

  // send one item, leaving valid high so a back-to-back transfer can follow
  task automatic send_item(input in_t it);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      if (valid_high) in_valid_i <= 1'b0;
      valid_high = 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    valid_high = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    registry_apply(it);
  endtask

  task automatic drop_valid();
    if (valid_high) in_valid_i <= 1'b0;
    valid_high = 1'b0;
  endtask

  // wait until every result is in, then let any dropped item finish
  task automatic wait_idle();
    drop_valid();
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_timeout(input logic [15:0] value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    timeout_s = value;
  endtask

  function automatic in_t frame_item(input logic [31:0] id);
    logic [191:0] raw;
    in_t          it;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(in_t)-1:0];
    it.func    = FUNC_FRAME;
    it.node_id = id;
    return it;
  endfunction

  function automatic in_t ctl_item(input logic [1:0] f, input logic [3:0] rs);
    logic [191:0] raw;
    in_t          it;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(in_t)-1:0];
    it.func      = f;
    it.read_slot = rs;
    return it;
  endfunction

  // compare one result field
  task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, e, a);
    end
  endtask

  // result side: random stall, check each transfer
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $realtime, out_data_o);
      end else begin
        check_field("status", 32'(pending_results[0].status), 32'(out_data_o.status));
        check_field("slot", 32'(pending_results[0].slot), 32'(out_data_o.slot));
        check_field("entry_valid", 32'(pending_results[0].entry_valid),
                    32'(out_data_o.entry_valid));
        check_field("lost_flag", 32'(pending_results[0].lost_flag),
                    32'(out_data_o.lost_flag));
        check_field("entry_id", pending_results[0].entry_id, out_data_o.entry_id);
        check_field("descriptor", pending_results[0].descriptor, out_data_o.descriptor);
        check_field("temperature", 32'(pending_results[0].entry_temperature),
                    32'(out_data_o.entry_temperature));
        check_field("humidity", 32'(pending_results[0].entry_humidity),
                    32'(out_data_o.entry_humidity));
        check_field("battery_mv", 32'(pending_results[0].entry_battery_mv),
                    32'(out_data_o.entry_battery_mv));
        check_field("wakeup_s", 32'(pending_results[0].entry_wakeup_s),
                    32'(out_data_o.entry_wakeup_s));
        check_field("runtime_s", pending_results[0].entry_runtime_s,
                    out_data_o.entry_runtime_s);
        check_field("frames", pending_results[0].entry_frames, out_data_o.entry_frames);
        void'(pending_results.pop_front());
      end
      if ($urandom_range(0, 39) == 0) rx_idle_on = !rx_idle_on;
      rx_wait = rx_idle_on ? $urandom_range(0, 18) : 0;
    end else if (rx_wait > 0) begin
      rx_wait--;
    end
    out_stall_i <= (rx_wait > 0);
  end

  // field extremes, updates, reads of empty and filled slots, unused code
  task automatic test_directed();
    in_t it;
    it = '0;
    it.func = FUNC_FRAME;
    send_item(it);
    it = '1;
    it.func = FUNC_FRAME;
    send_item(it);
    it.temperature = 16'sh8000;
    it.humidity    = 16'sh8000;
    send_item(it);
    send_item(frame_item(32'h0000_0000));
    for (int s = 0; s < 4; s++) send_item(ctl_item(FUNC_READ, 4'(s)));
    send_item(ctl_item(FUNC_READ, 4'hF));
    send_item(ctl_item(FUNC_TICK, 4'h0));
    send_item(ctl_item(FUNC_UNUSED, 4'h0));
    send_item(ctl_item(FUNC_READ, 4'h1));
  endtask

  // zero timeout flags every valid slot on each tick
  task automatic test_zero_timeout();
    write_timeout(16'h0000);
    send_item(ctl_item(FUNC_TICK, 4'h0));
    send_item(ctl_item(FUNC_READ, 4'h0));
    send_item(ctl_item(FUNC_READ, 4'h1));
    send_item(frame_item(32'hFFFF_FFFF));
    send_item(ctl_item(FUNC_READ, 4'h1));
  endtask

  // one-second timeout with a run of ticks below it, a frame in the middle
  task automatic test_short_timeout();
    write_timeout(16'h0001);
    tx_idle_on = 1'b0;
    for (int n = 0; n < 300; n++) begin
      if (n == 150) send_item(frame_item(32'h0000_0000));
      send_item(ctl_item(FUNC_TICK, 4'h0));
    end
    tx_idle_on = 1'b1;
    for (int s = 0; s < 3; s++) send_item(ctl_item(FUNC_READ, 4'(s)));
    send_item(frame_item(32'hFFFF_FFFF));
    send_item(ctl_item(FUNC_READ, 4'h1));
  endtask

  // random traffic over a pool of ids larger than the table
  task automatic test_random(input logic [15:0] tmo, input int count);
    int pick;
    write_timeout(tmo);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 49) == 0) tx_idle_on = !tx_idle_on;
      pick = $urandom_range(0, 99);
      if (pick < 40)
        send_item(frame_item(id_pool[$urandom_range(0, POOL - 1)]));
      else if (pick < 44)
        send_item(frame_item($urandom));
      else if (pick < 70)
        send_item(ctl_item(FUNC_TICK, 4'h0));
      else if (pick < 96)
        send_item(ctl_item(FUNC_READ, 4'($urandom_range(0, 15))));
      else
        send_item(ctl_item(FUNC_UNUSED, 4'h0));
    end
  endtask

  initial begin
    tx_idle_on = 1'b1;
    valid_high = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    timeout_s = 16'(LIMIT_RST / MS_PER_S);
    clock_ms = '0;
    for (int i = 0; i < SLOTS; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_lost[i] = 1'b0;
      tbl_frames[i] = '0;
      tbl_id[i] = '0;
      tbl_desc[i] = '0;
      tbl_temp[i] = '0;
      tbl_hum[i] = '0;
      tbl_batt[i] = '0;
      tbl_wake[i] = '0;
      tbl_run[i] = '0;
      tbl_rx_ms[i] = '0;
    end
    for (int k = 0; k < POOL; k++)
      id_pool[k] = {27'($urandom_range(1, 32'h07FF_FFFF)), 5'(k)};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_zero_timeout();
    test_short_timeout();
    test_random(16'hFFFF, 160);
    test_random(16'h0001, 160);
    test_random(16'd300, 160);

    wait_idle();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/srt_pkg.sv
hw/rtl/srt_cell.sv
hw/rtl/sensor_registry_table.sv
test/sensor_registry_table_tb.sv
